// ----- rtl/core/pfe_pkg.sv -----
package pfe_pkg;

  localparam int MAX_EFFECTS_DEF     = 16;
  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int ENTRIES_PER_RES_DEF = 4;

  // Group buffer is sized for the widest legal result.
  localparam int GROUP_SLOTS = 4;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_SRC   = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PASS,
    S_SEARCH,
    S_READ,
    S_BLEND,
    S_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic cap;
    logic exec;
    logic search;
    logic rd;
    logic blend;
    logic acc;
    logic out_pass;
    logic out_grp;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic fade;
    logic srch_zero;
    logic hit;
    logic blend_done;
    logic grp_end;
    logic run_last;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/core/pfe_blend.sv -----
// One color channel: c - step*(c - t)/steps, restoring division one bit a cycle.
module pfe_blend (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [7:0]  c,
  input  logic [7:0]  t,
  input  logic [11:0] step,
  input  logic [11:0] steps,
  output logic        done,
  output logic [7:0]  res
);

  logic [19:0] rem_r;
  logic [7:0]  q_r;
  logic [7:0]  c_r;
  logic        neg_r;
  logic [11:0] steps_r;
  logic [2:0]  bit_r;
  logic        run_r;
  logic        done_r;
  logic [7:0]  mag;
  logic [19:0] dsh;

  assign mag = (c >= t) ? (c - t) : (t - c);
  assign dsh = 20'(steps_r) << bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      bit_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        bit_r <= 3'd7;
      end else if (run_r) begin
        if (bit_r == 3'd0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        bit_r <= bit_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r   <= {8'd0, step} * {12'd0, mag};
      c_r     <= c;
      neg_r   <= (c < t);
      steps_r <= steps;
      q_r     <= 8'd0;
    end else if (run_r) begin
      if (rem_r >= dsh) begin
        rem_r      <= rem_r - dsh;
        q_r[bit_r] <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign res  = neg_r ? (c_r + q_r) : (c_r - q_r);

endmodule

// ----- rtl/core/pfe_ctrl.sv -----
module pfe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  pfe_pkg::sts_t sts,
  output pfe_pkg::cmd_t cmd
);

  pfe_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfe_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfe_pkg::S_IDLE: begin
        if (in_valid) state_nxt = pfe_pkg::S_EXEC;
      end
      pfe_pkg::S_EXEC: begin
        case (sts.op)
          pfe_pkg::OP_SRC:  state_nxt = sts.fade ? pfe_pkg::S_IDLE : pfe_pkg::S_PASS;
          pfe_pkg::OP_TICK: state_nxt = pfe_pkg::S_SEARCH;
          default:          state_nxt = pfe_pkg::S_IDLE;
        endcase
      end
      pfe_pkg::S_PASS: begin
        if (sts.out_free) state_nxt = pfe_pkg::S_IDLE;
      end
      pfe_pkg::S_SEARCH: begin
        if (sts.srch_zero) state_nxt = pfe_pkg::S_IDLE;
        else if (sts.hit)  state_nxt = pfe_pkg::S_READ;
      end
      pfe_pkg::S_READ:  state_nxt = pfe_pkg::S_BLEND;
      pfe_pkg::S_BLEND: state_nxt = pfe_pkg::S_WAIT;
      pfe_pkg::S_WAIT: begin
        if (sts.blend_done) state_nxt = sts.grp_end ? pfe_pkg::S_OUT : pfe_pkg::S_READ;
      end
      pfe_pkg::S_OUT: begin
        if (sts.out_free) state_nxt = sts.run_last ? pfe_pkg::S_IDLE : pfe_pkg::S_READ;
      end
      default: state_nxt = pfe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.cap      = (state_r == pfe_pkg::S_IDLE) && in_valid;
    cmd.exec     = (state_r == pfe_pkg::S_EXEC);
    cmd.search   = (state_r == pfe_pkg::S_SEARCH);
    cmd.rd       = (state_r == pfe_pkg::S_READ);
    cmd.blend    = (state_r == pfe_pkg::S_BLEND);
    cmd.acc      = (state_r == pfe_pkg::S_WAIT) && sts.blend_done;
    cmd.out_pass = (state_r == pfe_pkg::S_PASS) && sts.out_free;
    cmd.out_grp  = (state_r == pfe_pkg::S_OUT) && sts.out_free;
  end

  assign in_stall = (state_r != pfe_pkg::S_IDLE);

endmodule

// ----- rtl/core/pfe_dp.sv -----
module pfe_dp #(
  parameter int MAX_EFFECTS        = pfe_pkg::MAX_EFFECTS_DEF,
  parameter int PALETTE_ENTRIES    = pfe_pkg::PALETTE_ENTRIES_DEF,
  parameter int ENTRIES_PER_RESULT = pfe_pkg::ENTRIES_PER_RES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pfe_pkg::cmd_t cmd,
  output pfe_pkg::sts_t sts,
  input  logic [1:0]    in_op,
  input  logic [7:0]    in_entry_index,
  input  logic [7:0]    in_red,
  input  logic [7:0]    in_green,
  input  logic [7:0]    in_blue,
  input  logic [15:0]   in_frame_number,
  input  logic [11:0]   in_fade_steps,
  input  logic          in_fade_out,
  input  logic          out_stall,
  output logic          out_valid,
  output logic          out_kind,
  output logic [7:0]    out_first_index,
  output logic [23:0]   out_color_a,
  output logic [23:0]   out_color_b,
  output logic [23:0]   out_color_c,
  output logic [23:0]   out_color_d,
  output logic          out_last
);

  localparam int IDXW = (MAX_EFFECTS > 1) ? $clog2(MAX_EFFECTS) : 1;
  localparam int CNTW = $clog2(MAX_EFFECTS + 1);
  localparam int AW   = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int PW   = $clog2(PALETTE_ENTRIES + 1);

  // Latched transaction
  pfe_pkg::op_t op_r;
  logic [7:0]   idx_r;
  logic [23:0]  rgb_r;
  logic [15:0]  frame_r;
  logic [11:0]  steps_r;
  logic         fout_r;

  // Effect table
  logic [15:0] fx_start_r [MAX_EFFECTS];
  logic [11:0] fx_steps_r [MAX_EFFECTS];
  logic        fx_fout_r  [MAX_EFFECTS];
  logic [23:0] fx_rgb_r   [MAX_EFFECTS];
  logic [CNTW-1:0] count_r;
  logic [CNTW-1:0] srch_r;
  logic [CNTW-1:0] srch_m1;
  logic            fade_r;

  // Hit effect
  logic [11:0] h_step_r;
  logic [11:0] h_steps_r;
  logic        h_fout_r;
  logic [23:0] h_rgb_r;

  // Source palette
  logic [23:0]                src_mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] src_vld_r;
  logic [23:0]                rd_data_r;
  logic                       rd_vld_r;

  // Run control
  logic [PW-1:0] p_r;
  logic [PW-1:0] base_r;
  logic [1:0]    j_r;
  logic [23:0]   grp_r [pfe_pkg::GROUP_SLOTS];

  logic          out_valid_r;
  logic          out_free;

  logic [15:0] e_start;
  logic [11:0] e_steps;
  logic [16:0] e_end;
  logic        hit;
  logic [23:0] src_pix;
  logic [7:0]  bl_c [3];
  logic [7:0]  bl_t [3];
  logic [7:0]  bl_res [3];
  logic [2:0]  bl_done;

  assign srch_m1 = srch_r - CNTW'(1);
  assign e_start = fx_start_r[srch_m1[IDXW-1:0]];
  assign e_steps = fx_steps_r[srch_m1[IDXW-1:0]];
  assign e_end   = {1'b0, e_start} + {5'd0, e_steps} - 17'd1;
  assign hit     = (e_steps != 12'd0) && (frame_r >= e_start) && ({1'b0, frame_r} <= e_end);

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r    <= pfe_pkg::op_t'(in_op);
      idx_r   <= in_entry_index;
      rgb_r   <= {in_red, in_green, in_blue};
      frame_r <= in_frame_number;
      steps_r <= in_fade_steps;
      fout_r  <= in_fade_out;
    end
  end

  // Control state: count, flag, valid bits, search pointer, run pointers, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      fade_r      <= 1'b0;
      src_vld_r   <= '0;
      srch_r      <= '0;
      p_r         <= '0;
      base_r      <= '0;
      j_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        case (op_r)
          pfe_pkg::OP_CLEAR: begin
            count_r   <= '0;
            fade_r    <= 1'b0;
            src_vld_r <= '0;
          end
          pfe_pkg::OP_ADD: begin
            if (count_r < CNTW'(MAX_EFFECTS)) begin
              count_r <= count_r + CNTW'(1);
              if (frame_r <= 16'd1) fade_r <= 1'b1;
            end
          end
          pfe_pkg::OP_SRC: begin
            if ({1'b0, idx_r} < 9'(PALETTE_ENTRIES)) src_vld_r[idx_r[AW-1:0]] <= 1'b1;
          end
          pfe_pkg::OP_TICK: srch_r <= count_r;
          default: ;
        endcase
      end
      if (cmd.search) begin
        if (srch_r == '0) begin
          fade_r <= 1'b0;
        end else if (hit) begin
          fade_r <= 1'b1;
          p_r    <= '0;
          base_r <= '0;
          j_r    <= 2'd0;
        end else begin
          srch_r <= srch_m1;
        end
      end
      if (cmd.acc) begin
        p_r <= p_r + PW'(1);
        if (!sts.grp_end) j_r <= j_r + 2'd1;
      end
      if (cmd.out_grp) begin
        j_r    <= 2'd0;
        base_r <= p_r;
      end
      if (cmd.out_pass || cmd.out_grp) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Effect table writes
  always_ff @(posedge clk) begin
    if (cmd.exec && (op_r == pfe_pkg::OP_ADD) && (count_r < CNTW'(MAX_EFFECTS))) begin
      fx_start_r[count_r[IDXW-1:0]] <= frame_r;
      fx_steps_r[count_r[IDXW-1:0]] <= steps_r;
      fx_fout_r[count_r[IDXW-1:0]]  <= fout_r;
      fx_rgb_r[count_r[IDXW-1:0]]   <= rgb_r;
    end
  end

  // Latch the hit effect
  always_ff @(posedge clk) begin
    if (cmd.search && (srch_r != '0) && hit) begin
      h_step_r  <= 12'(frame_r - e_start + 16'd1);
      h_steps_r <= e_steps;
      h_fout_r  <= fx_fout_r[srch_m1[IDXW-1:0]];
      h_rgb_r   <= fx_rgb_r[srch_m1[IDXW-1:0]];
    end
  end

  // Source palette memory
  always_ff @(posedge clk) begin
    if (cmd.exec && (op_r == pfe_pkg::OP_SRC) && ({1'b0, idx_r} < 9'(PALETTE_ENTRIES))) begin
      src_mem[idx_r[AW-1:0]] <= rgb_r;
    end
    if (cmd.rd) begin
      rd_data_r <= src_mem[p_r[AW-1:0]];
      rd_vld_r  <= src_vld_r[p_r[AW-1:0]];
    end
  end

  assign src_pix = rd_vld_r ? rd_data_r : 24'd0;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    assign bl_c[k] = h_fout_r ? src_pix[23-8*k -: 8] : h_rgb_r[23-8*k -: 8];
    assign bl_t[k] = h_fout_r ? h_rgb_r[23-8*k -: 8] : src_pix[23-8*k -: 8];
    pfe_blend u_blend (
      .clk   (clk),
      .rst_n (rst_n),
      .start (cmd.blend),
      .c     (bl_c[k]),
      .t     (bl_t[k]),
      .step  (h_step_r),
      .steps (h_steps_r),
      .done  (bl_done[k]),
      .res   (bl_res[k])
    );
  end

  // Group buffer; cleared at run start and after each group leaves
  always_ff @(posedge clk) begin
    if ((cmd.search && (srch_r != '0) && hit) || cmd.out_grp) begin
      for (int s = 0; s < pfe_pkg::GROUP_SLOTS; s++) grp_r[s] <= 24'd0;
    end else if (cmd.acc) begin
      grp_r[j_r] <= {bl_res[0], bl_res[1], bl_res[2]};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_pass) begin
      out_kind        <= 1'b0;
      out_first_index <= idx_r;
      out_color_a     <= rgb_r;
      out_color_b     <= 24'd0;
      out_color_c     <= 24'd0;
      out_color_d     <= 24'd0;
      out_last        <= 1'b1;
    end else if (cmd.out_grp) begin
      out_kind        <= 1'b1;
      out_first_index <= 8'(base_r);
      out_color_a     <= grp_r[0];
      out_color_b     <= grp_r[1];
      out_color_c     <= grp_r[2];
      out_color_d     <= grp_r[3];
      out_last        <= (p_r == PW'(PALETTE_ENTRIES));
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts            = '0;
    sts.op         = op_r;
    sts.fade       = fade_r;
    sts.srch_zero  = (srch_r == '0);
    sts.hit        = hit;
    sts.blend_done = &bl_done;
    sts.grp_end    = (j_r == 2'(ENTRIES_PER_RESULT - 1)) ||
                     (p_r == PW'(PALETTE_ENTRIES - 1));
    sts.run_last   = (p_r == PW'(PALETTE_ENTRIES));
    sts.out_free   = out_free;
  end

endmodule

// ----- rtl/core/palette_fade_engine.sv -----
// Pass-through (source write, no fade active): decode, then the output register once
// the output is free; add and clear finish at decode. Frame tick: effect table search
// from the newest effect, then per palette entry a source memory read, blend start,
// 8-step restoring divide and accumulate, emit per group. One transaction at a time.
// Reset (rst_n low, synchronous) empties the effect table, drops the fade flag and
// marks every source entry as zero through its valid bit.
module palette_fade_engine #(
  parameter int MAX_EFFECTS        = pfe_pkg::MAX_EFFECTS_DEF,
  parameter int PALETTE_ENTRIES    = pfe_pkg::PALETTE_ENTRIES_DEF,
  parameter int ENTRIES_PER_RESULT = pfe_pkg::ENTRIES_PER_RES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_entry_index,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [15:0] in_frame_number,
  input  logic [11:0] in_fade_steps,
  input  logic        in_fade_out,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_first_index,
  output logic [23:0] out_color_a,
  output logic [23:0] out_color_b,
  output logic [23:0] out_color_c,
  output logic [23:0] out_color_d,
  output logic        out_last
);

  pfe_pkg::cmd_t cmd;
  pfe_pkg::sts_t sts;

  // Controller: sequences each transaction through decode and, as its op needs, search, blend and emit.
  pfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: effect table, source palette memory, three channel dividers and
  // the output register that holds a result while the sink stalls.
  pfe_dp #(
    .MAX_EFFECTS        (MAX_EFFECTS),
    .PALETTE_ENTRIES    (PALETTE_ENTRIES),
    .ENTRIES_PER_RESULT (ENTRIES_PER_RESULT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_entry_index  (in_entry_index),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_frame_number (in_frame_number),
    .in_fade_steps   (in_fade_steps),
    .in_fade_out     (in_fade_out),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_first_index (out_first_index),
    .out_color_a     (out_color_a),
    .out_color_b     (out_color_b),
    .out_color_c     (out_color_c),
    .out_color_d     (out_color_d),
    .out_last        (out_last)
  );

  // A pass-through result is always a single, final transaction with empty slots.
  a_pass_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> out_last && out_color_b == 24'd0 &&
    out_color_c == 24'd0 && out_color_d == 24'd0)
    else $error("pass-through result malformed");

  // An accepted transaction makes the block busy in the cycle after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  // An accumulate never happens without a completed blend behind it.
  a_grp_after_blend: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc |-> sts.blend_done)
    else $error("accumulate without blend result");

endmodule
